// ===== sv/modbus_rtu_response_check_top_macros.svh =====
// Assertion macros used by the checker in mrc_checker.sv.
`ifndef MODBUS_RTU_RESPONSE_CHECK_TOP_MACROS_SVH
`define MODBUS_RTU_RESPONSE_CHECK_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define MRC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, off during reset.
`define MRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// Condition that must hold in the cycle after reset is seen.
`define MRC_ASSERT_AFTER_RESET(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("%m: post-reset check failed");

`endif

// ===== sv/mrc_pkg.sv =====
package mrc_pkg;

    localparam int RX_DEPTH       = 256;
    localparam int CNT_W          = $clog2(RX_DEPTH + 1);
    localparam int MIN_VALID_LEN  = 4;
    localparam int QUEUE_DEPTH    = 2;  // power of two
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  BYTE_MASK = 8'hFF;

    typedef enum logic [1:0] {
        REQ_BEGIN = 2'd0,
        REQ_BYTE  = 2'd1,
        REQ_END   = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_RESPONSE  = 3'd1,
        ST_BAD_LENGTH   = 3'd2,
        ST_CRC_ERROR    = 3'd3,
        ST_BAD_RESPONSE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_BYTE  = 2'd1,
        OP_END   = 2'd2
    } t_op;

    // Begin: b0 = address, b1 = function. Byte: b0 = data.
    typedef struct packed {
        t_op        op;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_cmd;

    // Byte-wise reflected Modbus CRC update.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b & BYTE_MASK};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/mrc_ifs.sv =====
interface mrc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] expected_address;
    logic [7:0] expected_function;
    logic [7:0] rx_byte;

    modport source (output valid, req_type, expected_address, expected_function, rx_byte,
                    input ready);
    modport sink (input valid, req_type, expected_address, expected_function, rx_byte,
                  output ready);
endinterface

interface mrc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] check_status;
    logic [8:0] frame_length;

    modport source (output valid, check_status, frame_length, input ready);
    modport sink (input valid, check_status, frame_length, output ready);
endinterface

// ===== sv/mrc_front.sv =====
module mrc_front (
    mrc_in_if.sink        i_req,
    input  logic          i_q_ready,
    output logic          o_q_push,
    output mrc_pkg::t_cmd o_q_cmd
);
    import mrc_pkg::*;

    logic w_is_cmd;

    // Decode the request; unused codes are taken and dropped.
    always_comb begin
        w_is_cmd   = 1'b1;
        o_q_cmd.op = OP_END;
        o_q_cmd.b0 = i_req.rx_byte;
        o_q_cmd.b1 = i_req.expected_function;
        unique case (i_req.req_type)
            REQ_BEGIN: begin
                o_q_cmd.op = OP_BEGIN;
                o_q_cmd.b0 = i_req.expected_address;
            end
            REQ_BYTE: begin
                o_q_cmd.op = OP_BYTE;
            end
            REQ_END: begin
                o_q_cmd.op = OP_END;
            end
            default: begin
                w_is_cmd = 1'b0;
            end
        endcase
    end

    assign i_req.ready = i_q_ready;
    assign o_q_push    = i_req.valid && i_q_ready && w_is_cmd;

endmodule

// ===== sv/mrc_queue.sv =====
module mrc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mrc_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output mrc_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import mrc_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              w_push, w_pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== sv/mrc_back.sv =====
module mrc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  mrc_pkg::t_cmd i_cmd,
    output logic          o_pop,
    mrc_out_if.source     o_rsp
);
    import mrc_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_older, n_older;
    logic [7:0]       r_newer, n_newer;
    logic [7:0]       r_rep_addr, n_rep_addr;
    logic [7:0]       r_rep_func, n_rep_func;
    logic [7:0]       r_want_addr, n_want_addr;
    logic [7:0]       r_want_func, n_want_func;
    logic             r_out_valid, n_out_valid;
    t_status          r_out_status;
    logic [8:0]       r_out_len;
    t_status          w_status;
    logic             w_out_free;
    logic             w_take_end;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign o_pop      = i_valid && ((i_cmd.op != OP_END) || w_out_free);
    assign w_take_end = o_pop && (i_cmd.op == OP_END);

    always_comb begin
        priority if (r_count == '0) begin
            w_status = ST_NO_RESPONSE;
        end else if (r_count <= CNT_W'(MIN_VALID_LEN)) begin
            w_status = ST_BAD_LENGTH;
        end else if (r_older != r_crc[7:0] || r_newer != r_crc[15:8]) begin
            w_status = ST_CRC_ERROR;
        end else if (r_rep_addr != r_want_addr || r_rep_func != r_want_func) begin
            w_status = ST_BAD_RESPONSE;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        n_count     = r_count;
        n_crc       = r_crc;
        n_older     = r_older;
        n_newer     = r_newer;
        n_rep_addr  = r_rep_addr;
        n_rep_func  = r_rep_func;
        n_want_addr = r_want_addr;
        n_want_func = r_want_func;
        n_out_valid = r_out_valid && !o_rsp.ready;
        if (o_pop) begin
            unique case (i_cmd.op)
                OP_BEGIN: begin
                    n_count     = '0;
                    n_crc       = CRC_INIT;
                    n_older     = '0;
                    n_newer     = '0;
                    n_rep_addr  = '0;
                    n_rep_func  = '0;
                    n_want_addr = i_cmd.b0;
                    n_want_func = i_cmd.b1;
                end
                OP_BYTE: begin
                    // Drop bytes once the buffer is full.
                    if (r_count < CNT_W'(RX_DEPTH)) begin
                        if (r_count >= CNT_W'(2)) begin
                            n_crc = crc_feed(r_crc, r_older);
                        end
                        if (r_count == CNT_W'(0)) begin
                            n_rep_addr = i_cmd.b0;
                        end
                        if (r_count == CNT_W'(1)) begin
                            n_rep_func = i_cmd.b0;
                        end
                        n_older = r_newer;
                        n_newer = i_cmd.b0;
                        n_count = r_count + 1'b1;
                    end
                end
                OP_END: begin
                    n_out_valid = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_crc       <= CRC_INIT;
            r_older     <= '0;
            r_newer     <= '0;
            r_rep_addr  <= '0;
            r_rep_func  <= '0;
            r_want_addr <= '0;
            r_want_func <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_older     <= n_older;
            r_newer     <= n_newer;
            r_rep_addr  <= n_rep_addr;
            r_rep_func  <= n_rep_func;
            r_want_addr <= n_want_addr;
            r_want_func <= n_want_func;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_end) begin
            r_out_status <= w_status;
            r_out_len    <= 9'(r_count);
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.check_status = r_out_status;
    assign o_rsp.frame_length = r_out_len;

endmodule

// ===== sv/modbus_rtu_response_check_top.sv =====
// Modbus RTU reply checker.
// Input channel i_req carries one item per handshake: begin (loads expected
// address and function, clears the frame), byte (one received reply byte),
// or end (asks for the verdict). Code 3 is taken and ignored.
// Output channel o_rsp carries one item per end item: check_status and
// frame_length (bytes kept, saturated at the buffer depth).
// Throughput: one item per cycle on both sides while o_rsp.ready stays high; the
// CRC advances one byte per cycle in the back end.
// An accepted end item is first written into the queue; the back end pops it and
// registers its result onto o_rsp.
// Stall: a held result keeps o_rsp stable; byte and begin items behind it keep
// flowing into the back end until the next end item, then the two-entry
// queue fills and i_req.ready drops.
// Reset (i_rst_n low, synchronous): queue emptied, result dropped, frame state
// and expected address/function cleared, CRC set to all ones.
module modbus_rtu_response_check_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mrc_in_if.sink     i_req,
    mrc_out_if.source  o_rsp
);
    import mrc_pkg::*;

    logic q_push, q_ready, q_valid, q_pop;
    t_cmd q_in_cmd, q_out_cmd;

    mrc_front u_front (
        .i_req     (i_req),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_cmd   (q_in_cmd)
    );

    mrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd),
        .i_pop   (q_pop)
    );

    mrc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_out_cmd),
        .o_pop   (q_pop),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== sv/mrc_checker.sv =====
`include "modbus_rtu_response_check_top_macros.svh"

module mrc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    mrc_out_if.source o_rsp
);
    import mrc_pkg::*;

    `MRC_ASSERT_AFTER_RESET(a_no_result_after_reset, i_clk, i_rst_n, !o_rsp.valid)

    `MRC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_rsp.valid && !o_rsp.ready, o_rsp.valid && $stable(o_rsp.check_status) && $stable(o_rsp.frame_length))

    `MRC_ASSERT_IMPLY(a_no_resp_len, i_clk, i_rst_n, o_rsp.valid && o_rsp.check_status == ST_NO_RESPONSE, o_rsp.frame_length == 9'd0)

    `MRC_ASSERT_IMPLY(a_bad_len_range, i_clk, i_rst_n, o_rsp.valid && o_rsp.check_status == ST_BAD_LENGTH, o_rsp.frame_length != 9'd0 && o_rsp.frame_length <= 9'(MIN_VALID_LEN))

endmodule

bind modbus_rtu_response_check_top mrc_checker u_mrc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_rsp   (o_rsp)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mrc_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_LEN = 250;

    typedef struct packed {
        t_status    status;
        logic [8:0] length;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mrc_in_if  req_if ();
    mrc_out_if rsp_if ();

    modbus_rtu_response_check_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #4 i_clk = ~i_clk;

    // Predicted reply state
    int unsigned kept_bytes;
    logic [15:0] frame_crc;
    logic [7:0]  held_old;
    logic [7:0]  held_new;
    logic [7:0]  seen_address;
    logic [7:0]  seen_function;
    logic [7:0]  req_address;
    logic [7:0]  req_function;

    t_verdict pending_verdicts[$];

    int error_count = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int noise_pct = 0;
    int stall_cycles = 0;
    bit hold_req = 1'b0;
    bit hold_ack = 1'b0;
    int hold_left = 0;

    function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc,
                                                    input logic [7:0] data);
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ 16'hA001;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

    function automatic void clear_reply();
        kept_bytes = 0;
        frame_crc = 16'hFFFF;
        held_old = 8'h00;
        held_new = 8'h00;
        seen_address = 8'h00;
        seen_function = 8'h00;
    endfunction

    function automatic void track_reply_item(input logic [1:0] req, input logic [7:0] addr,
                                             input logic [7:0] func, input logic [7:0] data);
        t_verdict verdict;
        if (req == REQ_BEGIN) begin
            clear_reply();
            req_address = addr;
            req_function = func;
        end else if (req == REQ_BYTE) begin
            if (kept_bytes < RX_DEPTH) begin
                // the CRC lags two bytes behind the newest one
                if (kept_bytes >= 2) begin
                    frame_crc = modbus_crc_byte(frame_crc, held_old);
                end
                if (kept_bytes == 0) begin
                    seen_address = data;
                end else if (kept_bytes == 1) begin
                    seen_function = data;
                end
                held_old = held_new;
                held_new = data;
                kept_bytes++;
            end
        end else if (req == REQ_END) begin
            if (kept_bytes == 0) begin
                verdict.status = ST_NO_RESPONSE;
            end else if (kept_bytes <= MIN_VALID_LEN) begin
                verdict.status = ST_BAD_LENGTH;
            end else if (held_old != frame_crc[7:0] || held_new != frame_crc[15:8]) begin
                verdict.status = ST_CRC_ERROR;
            end else if (seen_address != req_address || seen_function != req_function) begin
                verdict.status = ST_BAD_RESPONSE;
            end else begin
                verdict.status = ST_OK;
            end
            verdict.length = 9'(kept_bytes);
            pending_verdicts.push_back(verdict);
        end
    endfunction

    // Call at a rising edge; returns at the edge that accepts the item.
    task automatic send_item(input logic [1:0] req, input logic [7:0] addr,
                             input logic [7:0] func, input logic [7:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.req_type <= req;
        req_if.expected_address <= addr;
        req_if.expected_function <= func;
        req_if.rx_byte <= data;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        track_reply_item(req, addr, func, data);
        if (req != REQ_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic send_begin(input logic [7:0] addr, input logic [7:0] func);
        send_item(REQ_BEGIN, addr, func, 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_item(REQ_BYTE, 8'($urandom), 8'($urandom), data);
    endtask

    task automatic send_end();
        send_item(REQ_END, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_noise();
        send_item(REQ_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Begin, reply bytes with CRC (optionally flipped), trailing bytes, end; noise may precede bytes.
    task automatic send_frame(input logic [7:0] want_addr, input logic [7:0] want_func,
                              input logic [7:0] rep_addr, input logic [7:0] rep_func,
                              input int payload_len, input logic [15:0] crc_flip,
                              input int extra);
        logic [7:0]  frame[$];
        logic [15:0] crc;
        frame.push_back(rep_addr);
        frame.push_back(rep_func);
        repeat (payload_len) frame.push_back(8'($urandom));
        crc = 16'hFFFF;
        foreach (frame[i]) crc = modbus_crc_byte(crc, frame[i]);
        crc = crc ^ crc_flip;
        frame.push_back(crc[7:0]);
        frame.push_back(crc[15:8]);
        repeat (extra) frame.push_back(8'($urandom));
        send_begin(want_addr, want_func);
        foreach (frame[i]) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_noise();
            end
            send_byte(frame[i]);
        end
        send_end();
    endtask

    task automatic wait_drain();
        req_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        noise_pct = 0;
        send_end();
        send_noise();
        // a byte with no begin runs on the reset state
        send_byte(8'hFF);
        send_end();
        send_frame(8'hFF, 8'h00, 8'hFF, 8'h00, 1, 16'h0000, 0);
        send_end();
        // four bytes, CRC correct but too short
        send_frame(8'h00, 8'hFF, 8'h00, 8'hFF, 0, 16'h0000, 0);
    endtask

    task automatic test_random_traffic(input int count);
        int stop_at;
        int pick;
        logic [7:0] want_a;
        logic [7:0] want_f;
        logic [7:0] rep_a;
        logic [7:0] rep_f;
        int payload;
        stop_at = items_sent + count;
        noise_pct = 5;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            want_a = 8'($urandom);
            want_f = 8'($urandom);
            payload = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(0, 12);
            if (pick < 55) begin
                send_frame(want_a, want_f, want_a, want_f, payload, 16'h0000, 0);
            end else if (pick < 65) begin
                send_frame(want_a, want_f, want_a, want_f, payload,
                           16'($urandom_range(1, 16'hFFFF)), 0);
            end else if (pick < 75) begin
                rep_a = want_a;
                rep_f = want_f;
                case ($urandom_range(0, 2))
                    0: rep_a = want_a ^ 8'($urandom_range(1, 255));
                    1: rep_f = want_f ^ 8'($urandom_range(1, 255));
                    default: begin
                        rep_a = want_a ^ 8'($urandom_range(1, 255));
                        rep_f = want_f ^ 8'($urandom_range(1, 255));
                    end
                endcase
                send_frame(want_a, want_f, rep_a, rep_f, payload, 16'h0000, 0);
            end else if (pick < 83) begin
                send_begin(want_a, want_f);
                repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
                send_end();
            end else if (pick < 88) begin
                // continue the current reply, then ask twice
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
                send_end();
                send_end();
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                              8'($urandom));
                end
            end else begin
                send_frame(want_a, want_f, want_a, want_f, payload, 16'h0000,
                           $urandom_range(1, 3));
            end
        end
    endtask

    task automatic test_backpressure();
        noise_pct = 0;
        hold_req = ~hold_req;
        repeat (12) begin
            send_begin(8'($urandom), 8'($urandom));
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
            send_end();
        end
        wait_drain();
    endtask

    task automatic test_overflow();
        logic [7:0] a;
        logic [7:0] f;
        noise_pct = 0;
        a = 8'($urandom);
        f = 8'($urandom);
        // exactly a full buffer with a good CRC, then dropped bytes
        send_frame(a, f, a, f, RX_DEPTH - 4, 16'h0000, 30);
        send_frame(a, f, a, f, RX_DEPTH + 40, 16'h0000, 0);
        send_end();
        wait_drain();
    endtask

    // Result checker and receiver ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: unexpected result status %0d length %0d", $time,
                             rsp_if.check_status, rsp_if.frame_length);
                    error_count++;
                end else begin
                    if (rsp_if.check_status !== pending_verdicts[0].status) begin
                        $display("%0t: check_status expected %0d actual %0d", $time,
                                 pending_verdicts[0].status, rsp_if.check_status);
                        error_count++;
                    end
                    if (rsp_if.frame_length !== pending_verdicts[0].length) begin
                        $display("%0t: frame_length expected %0d actual %0d", $time,
                                 pending_verdicts[0].length, rsp_if.frame_length);
                        error_count++;
                    end
                    void'(pending_verdicts.pop_front());
                end
            end
            if (hold_ack != hold_req) begin
                hold_ack = hold_req;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[modbus_rtu_response_check_top] ERROR");
            $finish;
        end
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.req_type = REQ_BEGIN;
        req_if.expected_address = 8'h00;
        req_if.expected_function = 8'h00;
        req_if.rx_byte = 8'h00;
        rsp_if.ready = 1'b0;
        kept_bytes = 0;
        frame_crc = 16'hFFFF;
        held_old = 8'h00;
        held_new = 8'h00;
        seen_address = 8'h00;
        seen_function = 8'h00;
        req_address = 8'h00;
        req_function = 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 17;
        recv_idle_pct = 73;
        test_directed();
        test_random_traffic(420);
        test_backpressure();

        send_idle_pct = 73;
        recv_idle_pct = 17;
        test_random_traffic(420);
        test_overflow();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(420);

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[modbus_rtu_response_check_top] OK");
        end else begin
            $display("[modbus_rtu_response_check_top] ERROR");
        end
        $finish;
    end

endmodule
